FILE: rtl/pupil_clamp_to_circle_unit_macros.svh
// Assertion macros used by the checker of this block.
`ifndef PUPIL_CLAMP_TO_CIRCLE_UNIT_MACROS_SVH
`define PUPIL_CLAMP_TO_CIRCLE_UNIT_MACROS_SVH

// Implication into the same cycle, ignored while reset is high.
`define PCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, ignored while reset is high.
`define PCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define PCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pcc_pkg.sv
package pcc_pkg;

  // Field and internal widths fixed by the item format.
  localparam int PT_W      = 16;  // pointer and pupil coordinates
  localparam int WIN_W     = 12;  // window size registers
  localparam int CX_W      = 12;  // x center, up to 3*w/4
  localparam int CY_W      = 11;  // y center, h/2
  localparam int HW_W      = 10;  // w/4
  localparam int RAD_W     = 10;  // radius, at most 575
  localparam int DW        = 17;  // pointer minus center
  localparam int SQ_W      = 2 * DW;
  localparam int RADM_W    = 15;  // radius candidate before the divide, up to 2047*9

  // Eye geometry: radius = size * (EYE_OUTER - EYE_PUPIL) / RAD_DEN.
  localparam int RAD_DEN   = 16;
  localparam int EYE_OUTER = 13;
  localparam int EYE_PUPIL = 4;
  localparam int RAD_MUL   = EYE_OUTER - EYE_PUPIL;

  // Inverse CORDIC gain, 32 fractional bits.
  localparam int GAIN_W    = 32;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_WIDTH_RESET  = 12'd160;
  localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RESET = 12'd120;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RSQ,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_TEST,
    ST_VEC,
    ST_ROT,
    ST_EYE,
    ST_DONE
  } pcc_state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic start;     // a new, non-repeated pointer was taken
    logic in_rad;    // pointer lies within the radius
    logic out_free;  // output register can take a result
  } pcc_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic setup;
    logic rsq;
    logic diff;
    logic sqx;
    logic sqy;
    logic test;
    logic vec;
    logic rot;
    logic eye_done;
    logic out_load;
    logic step_last;
  } pcc_ctrl_t;

endpackage

FILE: rtl/pupil_clamp_to_circle_unit.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// input     | in        | in_valid/in_stall  | pointer_x, pointer_y
// output    | out       | out_valid/out_stall| left_pupil_x/_y, right_pupil_x/_y
// config    | in        | cfg_write          | cfg_index, cfg_data (no read-back)
//
// An item that causes a result skips the CORDIC work for an eye whose circle holds the
// pointer; an eye that needs the clamp runs a vectoring pass and a rotation pass, both on
// the one shared micro-rotation unit. A repeated pointer is taken and dropped without a
// result. Reset is synchronous and active high; it restores the window size to 160 x 120
// and the last pointer to (-1,-1). in_stall is high for as long as an item is being
// worked on, and a finished result waits in the output register while out_stall is high.
module pupil_clamp_to_circle_unit import pcc_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIN_W-1:0]      cfg_data,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [PT_W-1:0] pointer_x,
  input  logic signed [PT_W-1:0] pointer_y,
  // Output channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [PT_W-1:0] left_pupil_x,
  output logic signed [PT_W-1:0] left_pupil_y,
  output logic signed [PT_W-1:0] right_pupil_x,
  output logic signed [PT_W-1:0] right_pupil_y
);

  // The CORDIC registers hold the offset scaled by 2^FRAC_BITS, plus room for the
  // gain of the vectoring pass.
  localparam int CW      = DW + FRAC_BITS + 2;
  localparam int TW      = CW - FRAC_BITS;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int PROD_W  = RAD_W + GAIN_W;
  localparam logic [PROD_W-1:0] U0_ROUND = PROD_W'(1) << (31 - FRAC_BITS);
  localparam logic signed [CW-1:0] TRUNC_BIAS = CW'((64'd1 << FRAC_BITS) - 64'd1);

  pcc_stat_t         stat;
  pcc_ctrl_t         ctrl;
  logic [STEP_W-1:0] step;
  logic              eye;

  // Window size registers.
  logic [WIN_W-1:0] win_w;
  logic [WIN_W-1:0] win_h;

  // Last pointer that produced a result.
  logic [PT_W-1:0] last_x;
  logic [PT_W-1:0] last_y;

  // Item registers.
  logic signed [PT_W-1:0] px;
  logic signed [PT_W-1:0] py;
  logic [CY_W-1:0]        cy;
  logic [CX_W-1:0]        clx;
  logic [CX_W-1:0]        crx;
  logic [RAD_W-1:0]       rad;
  logic [SQ_W-1:0]        rsq;
  logic signed [CW-1:0]   u0;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic [SQ_W-1:0]        sq;
  logic                   in_circle;
  logic                   flip;
  logic [CORDIC_STEPS-1:0] dir;
  logic signed [CW-1:0]   ax;
  logic signed [CW-1:0]   ay;
  logic signed [PT_W-1:0] lx;
  logic signed [PT_W-1:0] ly;
  logic signed [PT_W-1:0] rx;
  logic signed [PT_W-1:0] ry;

  // Combinational helpers.
  logic                   dup;
  logic [HW_W-1:0]        half_w;
  logic [CY_W-1:0]        half_h;
  logic [RADM_W-1:0]      rad_w;
  logic [RADM_W-1:0]      rad_h;
  logic [CX_W-1:0]        cx_sel;
  logic signed [DW-1:0]   mul_op;
  logic signed [SQ_W-1:0] mul_prod;
  logic [PROD_W-1:0]      gain_prod;
  logic [PROD_W-1:0]      u0_sum;
  logic signed [CW-1:0]   xs;
  logic signed [CW-1:0]   ys;
  logic                   sub;
  logic signed [CW-1:0]   ax_step;
  logic signed [CW-1:0]   ay_step;
  logic signed [CW-1:0]   ax_bias;
  logic signed [CW-1:0]   ay_bias;
  logic signed [TW-1:0]   tx;
  logic signed [TW-1:0]   ty;
  logic signed [TW-1:0]   vx;
  logic signed [TW-1:0]   vy;
  logic signed [TW-1:0]   ex;
  logic signed [TW-1:0]   ey;
  logic signed [PT_W-1:0] res_x;
  logic signed [PT_W-1:0] res_y;

  // A pointer equal to the last one is taken and dropped without a result.
  assign dup          = (pointer_x == last_x) && (pointer_y == last_y);
  assign in_stall     = ctrl.busy;
  assign stat.start   = in_valid && !in_stall && !dup;
  assign stat.in_rad  = (sq <= rsq);
  assign stat.out_free = !out_valid || !out_stall;

  pcc_seq #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .STEP_W       (STEP_W)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .step (step),
    .eye  (eye)
  );

  // Eye geometry for the current window size. Both divides are by powers of two.
  always_comb begin
    half_w = HW_W'(win_w >> 2);
    half_h = CY_W'(win_h >> 1);
    rad_w  = (RADM_W'(half_w) * RADM_W'(RAD_MUL)) / RADM_W'(RAD_DEN);
    rad_h  = (RADM_W'(half_h) * RADM_W'(RAD_MUL)) / RADM_W'(RAD_DEN);
  end

  // The shared squarer serves the radius and both offset components.
  always_comb begin
    priority if (ctrl.rsq) begin
      mul_op = DW'(rad);
    end else if (ctrl.sqx) begin
      mul_op = dx;
    end else begin
      mul_op = dy;
    end
    mul_prod = mul_op * mul_op;
  end

  // Starting length of the rotation pass: radius over the CORDIC gain, rounded.
  always_comb begin
    gain_prod = PROD_W'(rad) * PROD_W'(INV_GAIN_Q32);
    u0_sum    = gain_prod + U0_ROUND;
  end

  assign cx_sel = eye ? crx : clx;
  assign xs     = CW'(dx) <<< FRAC_BITS;
  assign ys     = CW'(dy) <<< FRAC_BITS;

  // Vectoring turns toward the x axis; rotation replays the recorded turns.
  assign sub = ctrl.vec ? ay[CW-1] : dir[step];

  pcc_cordic_step #(
    .CW     (CW),
    .STEP_W (STEP_W)
  ) u_step (
    .a      (ax),
    .b      (ay),
    .shift  (step),
    .sub    (sub),
    .a_next (ax_step),
    .b_next (ay_step)
  );

  // Pupil position: the scaled vector is truncated toward zero, turned back by a half turn
  // when the offset pointed left, and added to the eye center; a pointer inside the circle is kept.
  always_comb begin
    ax_bias = ax + (ax[CW-1] ? TRUNC_BIAS : '0);
    ay_bias = ay + (ay[CW-1] ? TRUNC_BIAS : '0);
    tx      = signed'(ax_bias[CW-1:FRAC_BITS]);
    ty      = signed'(ay_bias[CW-1:FRAC_BITS]);
    vx      = flip ? -tx : tx;
    vy      = flip ? -ty : ty;
    ex      = vx + signed'(TW'(cx_sel));
    ey      = vy + signed'(TW'(cy));
    if (in_circle) begin
      res_x = px;
      res_y = py;
    end else begin
      res_x = ex[PT_W-1:0];
      res_y = ey[PT_W-1:0];
    end
  end

  // Configuration and last-pointer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_w  <= WINDOW_WIDTH_RESET;
      win_h  <= WINDOW_HEIGHT_RESET;
      last_x <= '1;
      last_y <= '1;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_WIDTH:  win_w <= cfg_data;
          REG_WINDOW_HEIGHT: win_h <= cfg_data;
        endcase
      end
      if (stat.start) begin
        last_x <= pointer_x;
        last_y <= pointer_y;
      end
    end
  end

  // Working registers of the item.
  always_ff @(posedge clk) begin
    if (stat.start) begin
      px <= pointer_x;
      py <= pointer_y;
    end
    if (ctrl.setup) begin
      cy  <= half_h;
      clx <= CX_W'(half_w);
      crx <= CX_W'((14'(win_w) * 14'd3) >> 2);
      rad <= RAD_W'((rad_w < rad_h) ? rad_w : rad_h);
    end
    if (ctrl.rsq) begin
      rsq <= SQ_W'(mul_prod);
      u0  <= CW'(u0_sum >> (32 - FRAC_BITS));
    end
    if (ctrl.diff) begin
      dx <= DW'(px) - DW'(cx_sel);
      dy <= DW'(py) - DW'(cy);
    end
    if (ctrl.sqx) begin
      sq <= SQ_W'(mul_prod);
    end
    if (ctrl.sqy) begin
      sq <= sq + SQ_W'(mul_prod);
    end
    if (ctrl.test) begin
      in_circle <= stat.in_rad;
      flip      <= dx[DW-1];
      ax        <= dx[DW-1] ? -xs : xs;
      ay        <= dx[DW-1] ? -ys : ys;
    end
    if (ctrl.vec) begin
      dir[step] <= ~ay[CW-1];
      if (ctrl.step_last) begin
        ax <= u0;
        ay <= '0;
      end else begin
        ax <= ax_step;
        ay <= ay_step;
      end
    end
    if (ctrl.rot) begin
      ax <= ax_step;
      ay <= ay_step;
    end
    if (ctrl.eye_done) begin
      if (eye) begin
        rx <= res_x;
        ry <= res_y;
      end else begin
        lx <= res_x;
        ly <= res_y;
      end
    end
  end

  // Output register: holds a result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      left_pupil_x  <= lx;
      left_pupil_y  <= ly;
      right_pupil_x <= rx;
      right_pupil_y <= ry;
    end
  end

endmodule

FILE: rtl/pcc_cordic_step.sv
module pcc_cordic_step import pcc_pkg::*; #(
  parameter int CW     = 35,
  parameter int STEP_W = 4
) (
  input  logic signed [CW-1:0]     a,
  input  logic signed [CW-1:0]     b,
  input  logic        [STEP_W-1:0] shift,
  input  logic                     sub,
  output logic signed [CW-1:0]     a_next,
  output logic signed [CW-1:0]     b_next
);

  logic signed [CW-1:0] a_sh;
  logic signed [CW-1:0] b_sh;

  // One micro-rotation; sub selects the direction of the turn.
  always_comb begin
    a_sh = a >>> shift;
    b_sh = b >>> shift;
    if (sub) begin
      a_next = a - b_sh;
      b_next = b + a_sh;
    end else begin
      a_next = a + b_sh;
      b_next = b - a_sh;
    end
  end

endmodule

FILE: rtl/pcc_seq.sv
module pcc_seq import pcc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int STEP_W       = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  pcc_stat_t         stat,
  output pcc_ctrl_t         ctrl,
  output logic [STEP_W-1:0] step,
  output logic              eye
);

  pcc_state_t state;
  pcc_state_t state_next;
  logic       step_last;

  assign step_last = (step == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      eye   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.vec || ctrl.rot) begin
        step <= step_last ? '0 : step + 1'b1;
      end
      if (ctrl.eye_done) begin
        eye <= ~eye;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (stat.start) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_RSQ;
      ST_RSQ:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_SQX;
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_TEST;
      ST_TEST:  state_next = stat.in_rad ? ST_EYE : ST_VEC;
      ST_VEC:   if (step_last) state_next = ST_ROT;
      ST_ROT:   if (step_last) state_next = ST_EYE;
      ST_EYE:   state_next = eye ? ST_DONE : ST_DIFF;
      ST_DONE:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.busy      = (state != ST_IDLE);
    ctrl.step_last = step_last;
    unique case (state)
      ST_IDLE:  ;
      ST_SETUP: ctrl.setup    = 1'b1;
      ST_RSQ:   ctrl.rsq      = 1'b1;
      ST_DIFF:  ctrl.diff     = 1'b1;
      ST_SQX:   ctrl.sqx      = 1'b1;
      ST_SQY:   ctrl.sqy      = 1'b1;
      ST_TEST:  ctrl.test     = 1'b1;
      ST_VEC:   ctrl.vec      = 1'b1;
      ST_ROT:   ctrl.rot      = 1'b1;
      ST_EYE:   ctrl.eye_done = 1'b1;
      ST_DONE:  ctrl.out_load = stat.out_free;
      default:  ;
    endcase
  end

endmodule

FILE: rtl/pcc_checker.sv
`include "pupil_clamp_to_circle_unit_macros.svh"

module pcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [0:0]  cfg_index,
  input logic [11:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] pointer_x,
  input logic [15:0] pointer_y,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] left_pupil_x,
  input logic [15:0] left_pupil_y,
  input logic [15:0] right_pupil_x,
  input logic [15:0] right_pupil_y
);

  // A result waiting on a stalled output keeps its value.
  `PCC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(left_pupil_x) && $stable(left_pupil_y) && $stable(right_pupil_x) && $stable(right_pupil_y), "stalled result changed")

  // Reset leaves no result pending.
  `PCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result pending after reset")

  // A new result only appears right after the block was busy with an item.
  `PCC_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result without work")

  // An idle block with an empty output produces nothing on its own.
  `PCC_ASSERT_NEXT(a_no_phantom, clk, rst, !in_stall && !out_valid, !out_valid, "result from idle block")

endmodule

bind pupil_clamp_to_circle_unit pcc_checker u_pcc_checker (.*);
